@@ hw/rtl/ffsa_pkg.sv @@
// Shared constants and types for the first-fit segment allocator.
`timescale 1ns / 1ps
package ffsa_pkg;
	localparam int FREE_ENTRIES_DEF = 16;
	localparam int ADDR_BITS_DEF = 32;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int MIN_BLOCK_DEF = 24;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] REG_PAGE_SHIFT = 2'd0;
	localparam logic [1:0] REG_HEAP_BASE = 2'd1;
	localparam logic [1:0] REG_HEAP_LIMIT = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;
endpackage

@@ hw/rtl/ffsa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module ffsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/first_fit_segment_allocator.sv @@
// Top level of the first-fit segment allocator.
// One request is taken while busy is low; its single result appears on
// done for one cycle. The free table lives in one RAM holding {base,size};
// each non-null request walks the table one entry per cycle (read, then
// compare), and a removal shifts later entries down one at a time (SHRD
// reads the next entry, SHWR writes it one slot lower). A free that drops a
// right neighbor but has no left neighbor yet walks the table again.
// Results cannot be stalled: sample them on the done cycle.
`timescale 1ns / 1ps
module first_fit_segment_allocator #(
	parameter int FREE_ENTRIES = ffsa_pkg::FREE_ENTRIES_DEF,
	parameter int ADDR_BITS = ffsa_pkg::ADDR_BITS_DEF,
	parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF,
	parameter int MIN_BLOCK = ffsa_pkg::MIN_BLOCK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] request_bytes,
	input  logic [31:0] block_address,
	input  logic [31:0] block_bytes,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] granted_address,
	output logic [31:0] granted_bytes
);
	localparam int IW = $clog2(FREE_ENTRIES);
	localparam int CW = $clog2(FREE_ENTRIES + 1);
	localparam int AW = ADDR_BITS;
	localparam int EW = AW + 32;
	localparam logic [CW-1:0] FULL = CW'(FREE_ENTRIES);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PREP  = 9'b000000010,
		S_SCAN  = 9'b000000100,
		S_CARVE = 9'b000001000,
		S_SHRD  = 9'b000010000,
		S_SHWR  = 9'b000100000,
		S_FIN   = 9'b001000000,
		S_WLEFT = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t st_q;
	logic [4:0] page_shift_q;
	logic [31:0] heap_limit_q;
	logic [AW-1:0] heap_top_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic op_q;
	logic [33:0] need_q;
	logic [AW-1:0] nb_q, nend_q;
	logic [32:0] ns_q;
	logic left_q, right_q;
	logic [IW-1:0] left_idx_q;
	logic [32:0] left_size_q;
	logic [AW-1:0] base_q;
	logic [33:0] seg_q;
	logic app_q;
	logic [AW-1:0] app_b_q;
	logic [31:0] app_s_q;
	logic [1:0] st_res_q;
	logic [31:0] ga_q, gb_q;
	logic done_q;

	logic we;
	logic [IW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	ffsa_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	wire [AW-1:0] r_base = rdata[EW-1:32];
	wire [31:0] r_size = rdata[31:0];
	wire [AW-1:0] r_end = r_base + AW'(r_size);
	wire [IW-1:0] idx_i = idx_q[IW-1:0];
	wire [IW-1:0] idx_n = IW'(idx_q + CW'(1));

	// page rounding of the request
	wire [47:0] page = 48'd1 << page_shift_q;
	wire [47:0] span = (48'(need_q) + page - 48'd1) & ~(page - 48'd1);
	wire [47:0] top_end = 48'(heap_top_q) + span;
	wire split_carve = span >= 48'(need_q) + 48'(MIN_BLOCK);
	wire [33:0] rn = (34'(request_bytes) + 34'd7) & ~34'd7;

	function automatic logic [32:0] sat(input logic [33:0] v);
		return (v > 34'hFFFFFFFF) ? 33'hFFFFFFFF : v[32:0];
	endfunction

	always_comb begin
		we = 1'b0;
		waddr = idx_i;
		wdata = '0;
		raddr = idx_i;
		case (st_q)
			S_SCAN: raddr = idx_n;
			S_SHRD: raddr = idx_n;
			S_SHWR: begin
				we = 1'b1;
				wdata = rdata;
			end
			S_FIN: begin
				we = app_q;
				waddr = cnt_q[IW-1:0];
				wdata = {app_b_q, app_s_q};
			end
			S_WLEFT: begin
				we = 1'b1;
				waddr = left_idx_q;
				wdata = {base_q, left_size_q[31:0]};
			end
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign done = done_q;
	assign status = st_res_q;
	assign granted_address = ga_q;
	assign granted_bytes = gb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			page_shift_q <= 5'd12;
			heap_limit_q <= 32'd1048576;
			heap_top_q <= AW'(4096);
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					ffsa_pkg::REG_PAGE_SHIFT: page_shift_q <= cfg_data[4:0];
					ffsa_pkg::REG_HEAP_BASE: heap_top_q <= AW'(cfg_data);
					ffsa_pkg::REG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (start) begin
					op_q <= req_type;
					idx_q <= '0;
					left_q <= 1'b0;
					right_q <= 1'b0;
					app_q <= 1'b0;
					ga_q <= '0;
					gb_q <= '0;
					st_res_q <= ffsa_pkg::ST_OK;
					need_q <= ((request_bytes < 32'(MIN_BLOCK)) ? 34'(MIN_BLOCK) : rn)
						+ 34'(HEADER_BYTES);
					nb_q <= AW'(block_address) - AW'(HEADER_BYTES);
					nend_q <= AW'(block_address) - AW'(HEADER_BYTES) + AW'(block_bytes);
					ns_q <= 33'(block_bytes);
					if ((req_type == ffsa_pkg::REQ_ALLOC && request_bytes == '0) ||
						(req_type == ffsa_pkg::REQ_FREE && block_address == '0)) begin
						st_res_q <= ffsa_pkg::ST_NULL;
						st_q <= S_DONE;
					end else begin
						st_q <= S_PREP;
					end
				end
				S_PREP: st_q <= (cnt_q == '0) ? ((op_q == ffsa_pkg::REQ_ALLOC) ? S_CARVE : S_FIN)
					: S_SCAN;
				S_SCAN: begin
					// rdata holds entry idx_q
					if (op_q == ffsa_pkg::REQ_ALLOC) begin
						if (34'(r_size) >= need_q) begin
							base_q <= r_base;
							seg_q <= 34'(r_size);
							st_q <= S_SHRD;
						end else if (idx_q + CW'(1) >= cnt_q) st_q <= S_CARVE;
						else idx_q <= idx_q + CW'(1);
					end else begin
						logic lhit, rhit;
						logic [32:0] lsz;
						lhit = !left_q && (r_end == nb_q);
						rhit = !right_q && (nend_q == r_base) && !lhit;
						lsz = left_size_q;
						if (lhit) begin
							left_q <= 1'b1;
							left_idx_q <= idx_i;
							base_q <= r_base;
							lsz = sat(34'(r_size) + 34'(ns_q));
						end
						if (rhit) begin
							right_q <= 1'b1;
							if (left_q) lsz = sat(34'(lsz) + 34'(r_size));
							else ns_q <= sat(34'(ns_q) + 34'(r_size));
							if (left_q && left_idx_q > idx_i) left_idx_q <= left_idx_q - IW'(1);
						end
						left_size_q <= lsz;
						if (rhit) st_q <= S_SHRD;
						else if ((left_q || lhit) && right_q) st_q <= S_WLEFT;
						else if (idx_q + CW'(1) >= cnt_q) st_q <= (left_q || lhit) ? S_WLEFT : S_FIN;
						else idx_q <= idx_q + CW'(1);
					end
				end
				S_CARVE: begin
					if (top_end > 48'(heap_limit_q)) begin
						st_res_q <= ffsa_pkg::ST_EXHAUSTED;
						st_q <= S_DONE;
					end else if (split_carve && cnt_q >= FULL) begin
						st_res_q <= ffsa_pkg::ST_FULL;
						st_q <= S_DONE;
					end else begin
						base_q <= heap_top_q;
						seg_q <= span[33:0];
						heap_top_q <= top_end[AW-1:0];
						st_q <= S_FIN;
						idx_q <= cnt_q;
					end
				end
				S_SHRD: begin
					// remove entry idx_q: read idx+1 then write to idx
					if (idx_q + CW'(1) >= cnt_q) begin
						cnt_q <= cnt_q - CW'(1);
						if (op_q == ffsa_pkg::REQ_FREE && !left_q) begin
							// right neighbor merged; keep looking for a left one
							idx_q <= '0;
							st_q <= S_PREP;
						end else begin
							st_q <= (op_q == ffsa_pkg::REQ_FREE) ? S_WLEFT : S_FIN;
						end
					end else st_q <= S_SHWR;
				end
				S_SHWR: begin
					idx_q <= idx_q + CW'(1);
					st_q <= S_SHRD;
				end
				S_FIN: begin
					if (op_q == ffsa_pkg::REQ_ALLOC) begin
						if (!app_q && seg_q >= need_q + 34'(MIN_BLOCK)) begin
							app_q <= 1'b1;
							app_b_q <= base_q + AW'(need_q);
							app_s_q <= 32'(seg_q - need_q);
							seg_q <= need_q;
						end else begin
							if (app_q) cnt_q <= cnt_q + CW'(1);
							ga_q <= 32'(base_q + AW'(HEADER_BYTES));
							gb_q <= seg_q[31:0];
							st_q <= S_DONE;
						end
					end else if (cnt_q >= FULL) begin
						st_res_q <= ffsa_pkg::ST_FULL;
						st_q <= S_DONE;
					end else if (!app_q) begin
						app_q <= 1'b1;
						app_b_q <= nb_q;
						app_s_q <= ns_q[31:0];
					end else begin
						cnt_q <= cnt_q + CW'(1);
						st_q <= S_DONE;
					end
				end
				S_WLEFT: st_q <= S_DONE;
				S_DONE: begin
					done_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
